// ===== hw/rtl/sdds_pkg.sv =====
// Shared types, constants and constant functions of the direct/diffuse split unit.
package sdds_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_W         = 17;
	localparam int RES_W         = 17;
	localparam int CU_W          = 15;
	localparam int DEN1_W        = 32;
	localparam int PADDR_W       = 4;
	localparam int PDATA_W       = 32;

	localparam logic [RES_W-1:0] ONE_Q16 = 17'd65536;

	localparam logic [CFG_W-1:0] LOCAL_RST = 17'd101325;
	localparam logic [CFG_W-1:0] SEA_RST   = 17'd101325;
	localparam logic [CFG_W-1:0] TRANS_RST = 17'd55705;
	localparam logic [CFG_W-1:0] SCAT_RST  = 17'd19661;

	typedef enum logic [1:0] {
		REG_LOCAL = 2'd0,
		REG_SEA   = 2'd1,
		REG_TRANS = 2'd2,
		REG_SCAT  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [RES_W-1:0] direct_trans;
		logic [RES_W-1:0] diffuse_trans;
		logic [RES_W-1:0] direct_frac;
		logic [RES_W-1:0] diffuse_frac;
	} result_t;

	// Truncated integer square root, one result bit per iteration
	function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = x_in;
		r = '0;
		for (int i = 31; i >= 0; i--) begin
			b = 64'd1 << (2 * i);
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	// Factor 2^(-2^-k) in Q0.32, built by repeated square roots
	function automatic logic [31:0] exp_fac(input int k);
		logic [63:0] fac;
		fac = isqrt64(64'd1 << 63);
		for (int j = 1; j < k; j++) begin
			fac = isqrt64(fac << 32);
		end
		return fac[31:0];
	endfunction

endpackage

// ===== hw/rtl/sdds_div_cell.sv =====
// One restoring division cell: settles one quotient bit per cycle while en is high.
module sdds_div_cell #(
	parameter int DW = 32,
	parameter int QW = 32,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [DW-1:0] in_rem,
	input  logic [DW-1:0] in_den,
	input  logic [QW-1:0] in_q,
	input  logic [SW-1:0] in_side,
	input  logic          num_bit,
	output logic          out_valid,
	output logic [DW-1:0] out_rem,
	output logic [DW-1:0] out_den,
	output logic [QW-1:0] out_q,
	output logic [SW-1:0] out_side
);

	logic [DW:0]   trial;
	logic [DW:0]   dif;
	logic          ge;
	logic          valid_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] q_q;
	logic [SW-1:0] side_q;

	// Shift in the next numerator bit and try the subtraction
	assign trial = {in_rem, num_bit};
	assign ge    = trial >= {1'b0, in_den};
	assign dif   = trial - {1'b0, in_den};

	// Advance the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	// Advance the partial remainder and quotient
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? dif[DW-1:0] : trial[DW-1:0];
			den_q  <= in_den;
			q_q    <= {in_q[QW-2:0], ge};
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_rem   = rem_q;
	assign out_den   = den_q;
	assign out_q     = q_q;
	assign out_side  = side_q;

endmodule

// ===== hw/rtl/sdds_log_cell.sv =====
// One squaring cell of the log2 chain: produces one fraction bit per cycle.
module sdds_log_cell #(
	parameter int FW = 16
) (
	input  logic          clk,
	input  logic [30:0]   in_y,
	input  logic [FW-1:0] in_f,
	input  logic [4:0]    in_p,
	output logic [30:0]   out_y,
	output logic [FW-1:0] out_f,
	output logic [4:0]    out_p
);

	logic [61:0]   sq;
	logic [31:0]   y2;
	logic [30:0]   y_q;
	logic [FW-1:0] f_q;
	logic [4:0]    p_q;

	// Square the Q1.30 mantissa
	assign sq = 62'(in_y) * 62'(in_y);
	assign y2 = sq[61:30];

	// Renormalize and record the bit
	always_ff @(posedge clk) begin
		y_q <= y2[31] ? y2[31:1] : y2[30:0];
		f_q <= {in_f[FW-2:0], y2[31]};
		p_q <= in_p;
	end

	assign out_y = y_q;
	assign out_f = f_q;
	assign out_p = p_q;

endmodule

// ===== hw/rtl/sdds_exp_cell.sv =====
// One exp2 cell: applies one constant factor 2^(-2^-k) when its exponent bit is set.
module sdds_exp_cell #(
	parameter logic [31:0] FAC = 32'd0,
	parameter int          SW  = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [32:0]   in_val,
	input  logic          sel,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [32:0]   out_val,
	output logic [SW-1:0] out_side
);

	logic [64:0]   prod;
	logic          valid_q;
	logic [32:0]   val_q;
	logic [SW-1:0] side_q;

	assign prod = 65'(in_val) * 65'(FAC);

	// Advance the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	// Multiply in the factor or pass the value on
	always_ff @(posedge clk) begin
		if (en) begin
			val_q  <= sel ? prod[64:32] : in_val;
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_val   = val_q;
	assign out_side  = side_q;

endmodule

// ===== hw/rtl/solar_direct_diffuse_split_unit.sv =====
// Top level of the direct/diffuse sunlight split unit.
// One transaction per cycle is taken and one result per cycle is delivered while the skid
// slot is empty. An input runs from acceptance to output valid through the input stages,
// the divider chain for the airmass (2*FRAC_BITS+5 cells), the exp2 chain (FRAC_BITS
// cells), the diffuse stages and the fraction divider chain (17 cells). A two-entry output
// register lets the pipe keep moving while a result waits. The log2 of the transmittance
// register runs in a free-running chain of FRAC_BITS squaring cells and settles after a
// write, well before any item needs it. Registers are written over the APB port; the user
// must do so only while the unit is idle, as the block itself does not enforce it.
module solar_direct_diffuse_split_unit #(
	parameter int FRAC_BITS = sdds_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [sdds_pkg::PADDR_W-1:0]         paddr,
	input  logic [sdds_pkg::PDATA_W-1:0]         pwdata,
	output logic [sdds_pkg::PDATA_W-1:0]         prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [15:0]                   cos_zenith,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [sdds_pkg::RES_W-1:0]           direct_trans,
	output logic [sdds_pkg::RES_W-1:0]           diffuse_trans,
	output logic [sdds_pkg::RES_W-1:0]           direct_frac,
	output logic [sdds_pkg::RES_W-1:0]           diffuse_frac
);

	import sdds_pkg::*;

	localparam int EW     = 2 * FRAC_BITS + 5;
	localparam int EL     = EW / 2;
	localparam int EH     = EW - EL;
	localparam int MW     = FRAC_BITS + 5;
	localparam int PW     = MW + EW;
	localparam int SWD1   = CU_W + 2;
	localparam int SWE    = CU_W + 7 + FRAC_BITS;
	localparam int DEN2_W = RES_W + 1;
	localparam int SWD2   = 3 * RES_W + 2;
	localparam int ND2    = RES_W;

	// Configuration registers
	logic [CFG_W-1:0] local_q;
	logic [CFG_W-1:0] sea_q;
	logic [CFG_W-1:0] trans_q;
	logic [CFG_W-1:0] scat_q;
	reg_idx_t         reg_idx;

	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign pready  = 1'b1;

	// Write configuration on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_q <= LOCAL_RST;
			sea_q   <= SEA_RST;
			trans_q <= TRANS_RST;
			scat_q  <= SCAT_RST;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_LOCAL: local_q <= pwdata[CFG_W-1:0];
				REG_SEA:   sea_q   <= pwdata[CFG_W-1:0];
				REG_TRANS: trans_q <= pwdata[CFG_W-1:0];
				REG_SCAT:  scat_q  <= pwdata[CFG_W-1:0];
				default:   local_q <= local_q;
			endcase
		end
	end

	// Read back configuration
	always_comb begin
		unique case (reg_idx)
			REG_LOCAL: prdata = {{(PDATA_W-CFG_W){1'b0}}, local_q};
			REG_SEA:   prdata = {{(PDATA_W-CFG_W){1'b0}}, sea_q};
			REG_TRANS: prdata = {{(PDATA_W-CFG_W){1'b0}}, trans_q};
			REG_SCAT:  prdata = {{(PDATA_W-CFG_W){1'b0}}, scat_q};
			default:   prdata = '0;
		endcase
	end

	// Clamp the configuration
	logic [CFG_W-1:0] sea_eff;
	logic [CFG_W-1:0] t_eff;
	assign sea_eff = (sea_q == '0) ? CFG_W'(1) : sea_q;
	assign t_eff   = (trans_q > ONE_Q16) ? ONE_Q16 : trans_q;

	// Global advance; the output skid register frees the pipe for one more result
	logic en;
	logic skid_v_q;
	assign en       = !skid_v_q;
	assign in_ready = en;

	// ---------------- log2 chain of the transmittance ----------------
	logic [4:0]           t_msb;
	logic [30:0]          ly   [FRAC_BITS+1];
	logic [FRAC_BITS-1:0] lf   [FRAC_BITS+1];
	logic [4:0]           lp   [FRAC_BITS+1];
	logic [30:0]          logy_q;
	logic [4:0]           logp_q;
	logic [MW-1:0]        m_q;

	// Find the leading one of the transmittance
	always_comb begin
		t_msb = '0;
		for (int i = 0; i < CFG_W; i++) begin
			if (t_eff[i]) begin
				t_msb = 5'(i);
			end
		end
	end

	// Normalize the mantissa to Q1.30
	always_ff @(posedge clk) begin
		logy_q <= {14'd0, t_eff} << (5'd30 - t_msb);
		logp_q <= t_msb;
	end

	assign ly[0] = logy_q;
	assign lf[0] = '0;
	assign lp[0] = logp_q;

	for (genvar i = 0; i < FRAC_BITS; i++) begin : g_log
		sdds_log_cell #(.FW(FRAC_BITS)) u_cell (
			.clk   (clk),
			.in_y  (ly[i]),
			.in_f  (lf[i]),
			.in_p  (lp[i]),
			.out_y (ly[i+1]),
			.out_f (lf[i+1]),
			.out_p (lp[i+1])
		);
	end

	// Form -log2 of the transmittance
	always_ff @(posedge clk) begin
		m_q <= {(5'd16 - lp[FRAC_BITS]), {FRAC_BITS{1'b0}}} - {5'd0, lf[FRAC_BITS]};
	end

	// ---------------- stage 1: input and divisor ----------------
	logic              v_s1;
	logic              pos_s1;
	logic [CU_W-1:0]   cu_s1;
	logic [DEN1_W-1:0] den_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	// Capture the cosine and form sea-level pressure times cosine
	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1 <= !cos_zenith[15] && (cos_zenith != '0);
			cu_s1  <= cos_zenith[CU_W-1:0];
			den_s1 <= DEN1_W'(sea_eff) * DEN1_W'(cos_zenith[CU_W-1:0]);
		end
	end

	// ---------------- stage 2: airmass divider head ----------------
	logic [CFG_W-1:0]  hi_num;
	logic [EW-1:0]     num_lo;
	logic              dv1_v    [EW+1];
	logic [DEN1_W-1:0] dv1_rem  [EW+1];
	logic [DEN1_W-1:0] dv1_den  [EW+1];
	logic [EW-1:0]     dv1_q    [EW+1];
	logic [SWD1-1:0]   dv1_side [EW+1];
	logic              v_s2;
	logic [DEN1_W-1:0] rem_s2;
	logic [DEN1_W-1:0] den_s2;
	logic [SWD1-1:0]   side_s2;

	// Split the numerator: the high part decides overflow, the rest feeds the cells
	assign hi_num = local_q >> (FRAC_BITS - 9);
	assign num_lo = {{(EW-CFG_W){1'b0}}, local_q} << (FRAC_BITS + 14);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s2  <= {{(DEN1_W-CFG_W){1'b0}}, hi_num};
			den_s2  <= den_s1;
			side_s2 <= {pos_s1, ({{(DEN1_W-CFG_W){1'b0}}, hi_num} >= den_s1), cu_s1};
		end
	end

	assign dv1_v[0]    = v_s2;
	assign dv1_rem[0]  = rem_s2;
	assign dv1_den[0]  = den_s2;
	assign dv1_q[0]    = '0;
	assign dv1_side[0] = side_s2;

	for (genvar i = 0; i < EW; i++) begin : g_dv1
		sdds_div_cell #(.DW(DEN1_W), .QW(EW), .SW(SWD1)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (dv1_v[i]),
			.in_rem    (dv1_rem[i]),
			.in_den    (dv1_den[i]),
			.in_q      (dv1_q[i]),
			.in_side   (dv1_side[i]),
			.num_bit   (num_lo[EW-1-i]),
			.out_valid (dv1_v[i+1]),
			.out_rem   (dv1_rem[i+1]),
			.out_den   (dv1_den[i+1]),
			.out_q     (dv1_q[i+1]),
			.out_side  (dv1_side[i+1])
		);
	end

	// ---------------- stage 3: low partial product of m * e ----------------
	logic             v_s3;
	logic [MW+EL-1:0] plo_s3;
	logic [EH-1:0]    ehi_s3;
	logic [SWD1-1:0]  side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= dv1_v[EW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s3  <= (MW+EL)'(m_q) * (MW+EL)'(dv1_q[EW][EL-1:0]);
			ehi_s3  <= dv1_q[EW][EW-1:EL];
			side_s3 <= dv1_side[EW];
		end
	end

	// ---------------- stage 4: full product and exp2 head ----------------
	logic [MW+EH-1:0] phi;
	logic [PW-1:0]    prod;
	logic             zero_d;
	logic             ex_v    [FRAC_BITS+1];
	logic [32:0]      ex_val  [FRAC_BITS+1];
	logic [SWE-1:0]   ex_side [FRAC_BITS+1];
	logic             v_s4;
	logic [SWE-1:0]   side_s4;

	assign phi    = (MW+EH)'(m_q) * (MW+EH)'(ehi_s3);
	assign prod   = {{EH{1'b0}}, plo_s3} + ({{EL{1'b0}}, phi} << EL);
	// Flag an exponent so large that the power underflows to zero
	assign zero_d = (prod[PW-1:EW] != '0) || (side_s3[CU_W] && (m_q != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= {side_s3[CU_W+1], zero_d, prod[EW-1:2*FRAC_BITS],
				side_s3[CU_W-1:0], prod[2*FRAC_BITS-1:FRAC_BITS]};
		end
	end

	assign ex_v[0]    = v_s4;
	assign ex_val[0]  = 33'd1 << 32;
	assign ex_side[0] = side_s4;

	for (genvar i = 0; i < FRAC_BITS; i++) begin : g_exp
		sdds_exp_cell #(.FAC(exp_fac(i + 1)), .SW(SWE)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (ex_v[i]),
			.in_val    (ex_val[i]),
			.sel       (ex_side[i][FRAC_BITS-1-i]),
			.in_side   (ex_side[i]),
			.out_valid (ex_v[i+1]),
			.out_val   (ex_val[i+1]),
			.out_side  (ex_side[i+1])
		);
	end

	// ---------------- stage 5: direct transmittance ----------------
	logic [4:0]       ex_n;
	logic [32:0]      ex_sh;
	logic [33:0]      ex_rnd;
	logic [RES_W-1:0] d_raw;
	logic             v_s5;
	logic             pos_s5;
	logic [CU_W-1:0]  cu_s5;
	logic [RES_W-1:0] d_s5;

	assign ex_n   = ex_side[FRAC_BITS][SWE-3:SWE-7];
	assign ex_sh  = ex_val[FRAC_BITS] >> ex_n;
	assign ex_rnd = ({1'b0, ex_sh} + 34'd32768) >> 16;

	// Apply the special cases of pressure and transmittance
	always_comb begin
		if (local_q == '0) begin
			d_raw = ONE_Q16;
		end else if (t_eff == '0 || ex_side[FRAC_BITS][SWE-2]) begin
			d_raw = '0;
		end else begin
			d_raw = ex_rnd[RES_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= ex_v[FRAC_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s5 <= ex_side[FRAC_BITS][SWE-1];
			cu_s5  <= ex_side[FRAC_BITS][FRAC_BITS+CU_W-1:FRAC_BITS];
			d_s5   <= d_raw;
		end
	end

	// ---------------- stages 6 to 8: diffuse transmittance ----------------
	logic             v_s6;
	logic             v_s7;
	logic             v_s8;
	logic [33:0]      a_s6;
	logic [48:0]      b_s7;
	logic [CU_W-1:0]  cu_s6;
	logic             pos_s6;
	logic             pos_s7;
	logic             pos_s8;
	logic [RES_W-1:0] d_s6;
	logic [RES_W-1:0] d_s7;
	logic [RES_W-1:0] d_s8;
	logic [RES_W-1:0] diff_s8;
	logic [49:0]      b_rnd;
	logic [19:0]      b_sh;

	assign b_rnd = {1'b0, b_s7} + (50'd1 << 29);
	assign b_sh  = b_rnd[49:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// Scale, multiply by cosine, round and saturate
	always_ff @(posedge clk) begin
		if (en) begin
			a_s6    <= 34'(scat_q) * 34'(ONE_Q16 - d_s5);
			cu_s6   <= cu_s5;
			pos_s6  <= pos_s5;
			d_s6    <= d_s5;
			b_s7    <= 49'(a_s6) * 49'(cu_s6);
			pos_s7  <= pos_s6;
			d_s7    <= d_s6;
			diff_s8 <= (b_sh > 20'(ONE_Q16)) ? ONE_Q16 : b_sh[RES_W-1:0];
			pos_s8  <= pos_s7;
			d_s8    <= d_s7;
		end
	end

	// ---------------- stage 9: fraction divider head ----------------
	logic [DEN2_W-1:0] den2;
	logic [33:0]       num2;
	logic              v_s9;
	logic [DEN2_W-1:0] rem_s9;
	logic [DEN2_W-1:0] den_s9;
	logic [SWD2-1:0]   side_s9;
	logic              dv2_v    [ND2+1];
	logic [DEN2_W-1:0] dv2_rem  [ND2+1];
	logic [DEN2_W-1:0] dv2_den  [ND2+1];
	logic [RES_W-1:0]  dv2_q    [ND2+1];
	logic [SWD2-1:0]   dv2_side [ND2+1];

	assign den2 = {1'b0, d_s8} + {1'b0, diff_s8};
	assign num2 = {1'b0, d_s8, 16'd0} + {17'd0, den2[DEN2_W-1:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	// The quotient fits in 17 bits, so the top bits start as the remainder
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s9  <= {1'b0, num2[33:17]};
			den_s9  <= den2;
			side_s9 <= {pos_s8, (den2 == '0), d_s8, diff_s8, num2[16:0]};
		end
	end

	assign dv2_v[0]    = v_s9;
	assign dv2_rem[0]  = rem_s9;
	assign dv2_den[0]  = den_s9;
	assign dv2_q[0]    = '0;
	assign dv2_side[0] = side_s9;

	for (genvar i = 0; i < ND2; i++) begin : g_dv2
		sdds_div_cell #(.DW(DEN2_W), .QW(RES_W), .SW(SWD2)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (dv2_v[i]),
			.in_rem    (dv2_rem[i]),
			.in_den    (dv2_den[i]),
			.in_q      (dv2_q[i]),
			.in_side   (dv2_side[i]),
			.num_bit   (dv2_side[i][ND2-1-i]),
			.out_valid (dv2_v[i+1]),
			.out_rem   (dv2_rem[i+1]),
			.out_den   (dv2_den[i+1]),
			.out_q     (dv2_q[i+1]),
			.out_side  (dv2_side[i+1])
		);
	end

	// ---------------- result assembly ----------------
	logic             tail_v;
	logic [RES_W-1:0] frac;
	result_t          tail_res;
	logic [SWD2-1:0]  tside;

	assign tail_v = dv2_v[ND2];
	assign tside  = dv2_side[ND2];

	always_comb begin
		if (tside[SWD2-2]) begin
			frac = '0;
		end else if (dv2_q[ND2] > ONE_Q16) begin
			frac = ONE_Q16;
		end else begin
			frac = dv2_q[ND2];
		end
		if (tside[SWD2-1]) begin
			tail_res.direct_trans  = tside[3*RES_W-1:2*RES_W];
			tail_res.diffuse_trans = tside[2*RES_W-1:RES_W];
			tail_res.direct_frac   = frac;
			tail_res.diffuse_frac  = ONE_Q16 - frac;
		end else begin
			tail_res.direct_trans  = '0;
			tail_res.diffuse_trans = '0;
			tail_res.direct_frac   = '0;
			tail_res.diffuse_frac  = ONE_Q16;
		end
	end

	// ---------------- output register and skid ----------------
	logic    out_v_q;
	result_t out_res_q;
	result_t skid_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (tail_v) begin
			if (out_v_q && !out_ready) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	// Park a result in the skid slot while the output waits
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_ready) begin
				out_res_q <= skid_res_q;
			end
		end else if (tail_v) begin
			if (out_v_q && !out_ready) begin
				skid_res_q <= tail_res;
			end else begin
				out_res_q <= tail_res;
			end
		end
	end

	assign out_valid     = out_v_q;
	assign direct_trans  = out_res_q.direct_trans;
	assign diffuse_trans = out_res_q.diffuse_trans;
	assign direct_frac   = out_res_q.direct_frac;
	assign diffuse_frac  = out_res_q.diffuse_frac;

endmodule

// ===== hw/rtl/sdds_checker.sv =====
// Port-level checks of the direct/diffuse split unit, bound to the top level.
module sdds_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [sdds_pkg::RES_W-1:0]    direct_trans,
	input logic [sdds_pkg::RES_W-1:0]    diffuse_trans,
	input logic [sdds_pkg::RES_W-1:0]    direct_frac,
	input logic [sdds_pkg::RES_W-1:0]    diffuse_frac
);

	import sdds_pkg::*;

	// Hold a stalled transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output transaction dropped while stalled");

	// Fractions always add up to one
	a_frac_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((RES_W+1)'(direct_frac) + (RES_W+1)'(diffuse_frac))
			== (RES_W+1)'(ONE_Q16))
		else $error("direct and diffuse fractions do not sum to one");

	// Transmittances and the direct fraction saturate at one
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> direct_trans <= ONE_Q16 && diffuse_trans <= ONE_Q16
			&& direct_frac <= ONE_Q16)
		else $error("result above one");

	// No light gives no direct fraction
	a_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && direct_trans == '0 && diffuse_trans == '0 |-> direct_frac == '0)
		else $error("nonzero direct fraction without light");

endmodule

bind solar_direct_diffuse_split_unit sdds_checker u_sdds_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.direct_trans  (direct_trans),
	.diffuse_trans (diffuse_trans),
	.direct_frac   (direct_frac),
	.diffuse_frac  (diffuse_frac)
);
